// ===== hdl/s256h_pkg.sv =====
// Shared types, round constants and helper functions for the SHA-256 byte stream hasher.
// No dependencies; compile first.
package s256h_pkg;

    typedef logic [31:0] s256h_word_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD    = 7'b0000010,
        ST_LEN_HI = 7'b0000100,
        ST_LEN_LO = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } s256h_state_t;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LEN_LO_POS = 6'd60;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [1:0] LAST_LANE = 2'd3;
    localparam logic [2:0] LAST_WORD = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam s256h_word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam s256h_word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic s256h_word_t ror32(input s256h_word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic s256h_word_t big_sigma0(input s256h_word_t x);
        big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic s256h_word_t big_sigma1(input s256h_word_t x);
        big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic s256h_word_t small_sigma0(input s256h_word_t x);
        small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic s256h_word_t small_sigma1(input s256h_word_t x);
        small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hdl/s256h_if.sv =====
// Valid/ready channel interfaces for the SHA-256 byte stream hasher.
// Byte request channel and digest word channel; no dependencies.
interface s256h_byte_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface s256h_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

// ===== hdl/sha256_byte_stream_hasher.sv =====
// SHA-256 hasher top level: byte packing, padding sequencer, shared round unit.
// Depends on s256h_pkg and the channel interfaces in s256h_if.sv.
//
// A message byte request (kind 0) packs its byte into the message block; every 64th byte
// also starts a block compression (64 rounds through the single round unit and a fold of
// the working variables into the chaining value). A finish request (kind 1) appends the
// 0x80 marker, writes zero bytes one per cycle up to byte 56 of a block (through one extra
// compression when 56 or more bytes are pending), writes the bit length high word first,
// then the low word, compresses, and presents the eight digest words H0..H7 one per
// cycle as the sink takes them. Requests are refused while a compression, padding or digest
// output runs; the final digest word may still be waiting on the output when the next
// message starts.
module sha256_byte_stream_hasher
    import s256h_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    s256h_byte_if.sink            msg,
    s256h_digest_if.source        digest
);

    s256h_state_t state_reg, state_next;

    s256h_word_t chain_reg [8];
    s256h_word_t chain_next [8];
    s256h_word_t work_reg [8];
    s256h_word_t work_next [8];
    s256h_word_t sched_reg [16];
    s256h_word_t sched_next [16];

    s256h_word_t word_acc_reg, word_acc_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic        last_blk_reg, last_blk_next;
    logic        pad_reg, pad_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;

    logic        out_valid_reg, out_valid_next;
    s256h_word_t out_word_reg, out_word_next;
    logic [2:0]  out_index_reg, out_index_next;
    logic        out_last_reg, out_last_next;

    logic        msg_take;
    logic        place_en;
    logic [7:0]  place_byte;
    logic        push_en;
    s256h_word_t push_word;
    logic        start_comp;
    s256h_word_t packed_word;
    s256h_word_t new_w;
    s256h_word_t t1;
    s256h_word_t t2;

    assign msg.ready = (state_reg == ST_IDLE);
    assign msg_take  = msg.valid && msg.ready;

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_index_reg;
    assign digest.last        = out_last_reg;

    assign packed_word = {word_acc_reg[23:0], place_byte};

    assign new_w = small_sigma1(sched_reg[14]) + sched_reg[9]
                 + small_sigma0(sched_reg[1]) + sched_reg[0];

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + sched_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        sched_next     = sched_reg;
        word_acc_next  = word_acc_reg;
        bytes_next     = bytes_reg;
        bits_next      = bits_reg;
        round_next     = round_reg;
        last_blk_next  = last_blk_reg;
        pad_next       = pad_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        place_en       = 1'b0;
        place_byte     = PAD_ZERO;
        push_en        = 1'b0;
        push_word      = bits_reg[31:0];
        start_comp     = 1'b0;

        if (out_valid_reg && digest.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_take)
                begin
                    place_en = 1'b1;
                    if (msg.kind == KIND_BYTE)
                    begin
                        place_byte = msg.data_byte;
                        bits_next  = bits_reg + BITS_PER_BYTE;
                    end
                    else
                    begin
                        place_byte = PAD_MARK;
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                    if (bytes_reg == LAST_POS)
                    begin
                        start_comp = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (bytes_reg == LEN_POS)
                begin
                    state_next = ST_LEN_HI;
                end
                else
                begin
                    place_en = 1'b1;
                    if (bytes_reg == LAST_POS)
                    begin
                        start_comp = 1'b1;
                    end
                end
            end
            ST_LEN_HI:
            begin
                push_en    = 1'b1;
                push_word  = bits_reg[63:32];
                bytes_next = LEN_LO_POS;
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                push_en       = 1'b1;
                push_word     = bits_reg[31:0];
                bytes_next    = '0;
                last_blk_next = 1'b1;
                start_comp    = 1'b1;
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    sched_next[i] = sched_reg[i + 1];
                end
                sched_next[15] = new_w;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                round_next   = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (last_blk_reg)
                begin
                    last_blk_next = 1'b0;
                    pad_next      = 1'b0;
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || digest.ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[emit_idx_reg];
                    out_index_next = emit_idx_reg;
                    out_last_next  = (emit_idx_reg == LAST_WORD);
                    emit_idx_next  = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == LAST_WORD)
                    begin
                        chain_next = INIT_HASH;
                        bytes_next = '0;
                        bits_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (place_en)
        begin
            word_acc_next = packed_word;
            bytes_next    = bytes_reg + 6'd1;
            if (bytes_reg[1:0] == LAST_LANE)
            begin
                push_en   = 1'b1;
                push_word = packed_word;
            end
        end

        if (push_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[15] = push_word;
        end

        if (start_comp)
        begin
            work_next  = chain_reg;
            round_next = '0;
            state_next = ST_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= INIT_HASH;
            bytes_reg     <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            last_blk_reg  <= 1'b0;
            pad_reg       <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            bytes_reg     <= bytes_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            last_blk_reg  <= last_blk_next;
            pad_reg       <= pad_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        sched_reg     <= sched_next;
        word_acc_reg  <= word_acc_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== hdl/s256h_chk.sv =====
// Port-level assertions for the SHA-256 byte stream hasher, bound to its top level.
// Depends on s256h_pkg and sha256_byte_stream_hasher.
module s256h_chk
    import s256h_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] word_index,
    input logic       last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("digest word dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (word_index == LAST_WORD)))
    else $error("last flag does not match word index");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last
        |=> out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words not delivered in order");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
    else $error("request taken while digest output runs");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == KIND_FINISH) |=> !in_ready)
    else $error("request taken right after finish");

endmodule

bind sha256_byte_stream_hasher s256h_chk u_s256h_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (msg.valid),
    .in_ready   (msg.ready),
    .in_kind    (msg.kind),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .word_index (digest.word_index),
    .last       (digest.last)
);

// ===== tb/sha256_byte_stream_hasher_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sha256_byte_stream_hasher: feeds byte and finish requests with
// random gaps and checks each digest word against an in-bench SHA-256 model.
// Depends on s256h_pkg and the channel interfaces in s256h_if.sv.
module sha256_byte_stream_hasher_test;
    import s256h_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 150;
    localparam int RANDOM_REQUESTS = 6;
    localparam int CALM_AFTER = 0;
    localparam int LONG_MESSAGE = 120;
    localparam int MAX_PRINTED = 40;
    localparam logic [7:0] PAD_START = 8'h80;
    localparam logic [7:0] PAD_FILL = 8'h00;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   requests_sent = 0;
    int   messages_done = 0;
    int   words_checked = 0;
    int   stall_left = 0;

    logic [31:0]   chain_h [8];
    logic [31:0]   block_w [16];
    logic [5:0]    block_fill;
    logic [63:0]   message_len_bits;
    digest_entry_t digest_due [$];

    s256h_byte_if   msg_if ();
    s256h_digest_if digest_if ();

    sha256_byte_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        chain_h = START_CHAIN;
        block_fill = '0;
        message_len_bits = '0;
    endfunction

    function automatic void compress_chain();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        int r;
        w = block_w;
        v = chain_h;
        for (r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                s0 = rotr(w[(r - 15) % 16], 7) ^ rotr(w[(r - 15) % 16], 18)
                     ^ (w[(r - 15) % 16] >> 3);
                s1 = rotr(w[(r - 2) % 16], 17) ^ rotr(w[(r - 2) % 16], 19)
                     ^ (w[(r - 2) % 16] >> 10);
                w[r % 16] = w[r % 16] + s1 + w[(r - 7) % 16] + s0;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r % 16];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++)
            chain_h[r] = chain_h[r] + v[r];
    endfunction

    function automatic void pack_message_byte(input logic [7:0] b);
        logic [1:0] lane;
        lane = block_fill[1:0];
        if (lane == 2'd0)
            block_w[block_fill[5:2]] = {b, 24'h0};
        else
            block_w[block_fill[5:2]] |= {24'h0, b} << ((3 - lane) * 8);
        block_fill = block_fill + 6'd1;
    endfunction

    function automatic void absorb_request(input logic kind, input logic [7:0] b);
        digest_entry_t entry;
        int j;
        if (kind == KIND_BYTE)
        begin
            pack_message_byte(b);
            message_len_bits = message_len_bits + 64'd8;
            if (block_fill == 6'd0)
                compress_chain();
        end
        else
        begin
            pack_message_byte(PAD_START);
            if (block_fill == 6'd0)
                compress_chain();
            else if (block_fill > 6'd56)
            begin
                while (block_fill != 6'd0)
                    pack_message_byte(PAD_FILL);
                compress_chain();
            end
            while (block_fill < 6'd56)
                pack_message_byte(PAD_FILL);
            block_w[14] = message_len_bits[63:32];
            block_w[15] = message_len_bits[31:0];
            block_fill = '0;
            compress_chain();
            for (j = 0; j < 8; j++)
            begin
                entry.word = chain_h[j];
                entry.index = j[2:0];
                entry.last = (j == 7);
                digest_due.push_back(entry);
            end
            restart_hash();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    task automatic send_request(input logic kind, input logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        msg_if.valid <= 1'b1;
        msg_if.kind <= kind;
        msg_if.data_byte <= b;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        absorb_request(kind, b);
        requests_sent++;
        if (kind == KIND_FINISH)
            messages_done++;
    endtask

    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_request(KIND_BYTE, 8'($urandom_range(0, 255)));
        send_request(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_digests();
        msg_if.valid <= 1'b0;
        while (digest_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_short_messages();
        send_request(KIND_FINISH, 8'h00);
        send_request(KIND_BYTE, 8'h61);
        send_request(KIND_BYTE, 8'h62);
        send_request(KIND_BYTE, 8'h63);
        send_request(KIND_FINISH, 8'hff);
        send_request(KIND_BYTE, 8'h00);
        send_request(KIND_FINISH, 8'h00);
        send_request(KIND_BYTE, 8'hff);
        send_request(KIND_FINISH, 8'hff);
        send_request(KIND_BYTE, 8'h55);
        send_request(KIND_BYTE, 8'haa);
        send_request(KIND_BYTE, 8'hff);
        send_request(KIND_BYTE, 8'h00);
        send_request(KIND_BYTE, 8'h01);
        send_request(KIND_FINISH, 8'h80);
        send_request(KIND_FINISH, 8'h7f);
        drain_digests();
    endtask

    task automatic test_padding_edges();
        send_message(LONG_MESSAGE);
        drain_digests();
    endtask

    task automatic test_random_messages();
        int first;
        int pick;
        first = requests_sent;
        while (requests_sent - first < RANDOM_REQUESTS)
        begin
            if (requests_sent - first >= CALM_AFTER)
                calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_message($urandom_range(0, 1));
            else if (pick < 9)
                send_message($urandom_range(2, 3));
            else
                send_message($urandom_range(4, 5));
        end
        drain_digests();
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words pending",
                     cycle_count, digest_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            digest_if.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            digest_if.ready <= 1'b0;
        end
        else
            digest_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        digest_entry_t want;
        if (rst_n && digest_if.valid && digest_if.ready)
        begin
            if (digest_due.size() == 0)
                report_mismatch("unexpected digest word", digest_if.digest_word, 32'h0);
            else
            begin
                want = digest_due.pop_front();
                words_checked++;
                if (digest_if.digest_word !== want.word)
                    report_mismatch("digest_word", digest_if.digest_word, want.word);
                if (digest_if.word_index !== want.index)
                    report_mismatch("word_index", 32'(digest_if.word_index), 32'(want.index));
                if (digest_if.last !== want.last)
                    report_mismatch("last", 32'(digest_if.last), 32'(want.last));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        msg_if.valid = 1'b0;
        msg_if.kind = KIND_BYTE;
        msg_if.data_byte = 8'h00;
        digest_if.ready = 1'b0;
        block_w = '{default: 32'h0};
        restart_hash();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_padding_edges();
        test_random_messages();

        repeat (TAIL_CYCLES) @(posedge clk);
        while (digest_due.size() != 0)
            @(posedge clk);
        $display("covered %0d requests in %0d messages, including the padding edges",
                 requests_sent, messages_done);
        $display("checked %0d digest words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
